[rtl/core/slex_pkg.sv]
// ----------------------------------------------------------------------------
// slex_pkg
// Shared types, codes and character classes of the script lexer core.
// ----------------------------------------------------------------------------
`default_nettype none

package slex_pkg;

  // Record kinds
  localparam logic [1:0] REC_VALUE = 2'd0;
  localparam logic [1:0] REC_KIND  = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  // Token kinds
  localparam logic [4:0] TK_NUM     = 5'd0;
  localparam logic [4:0] TK_STR     = 5'd1;
  localparam logic [4:0] TK_IDENT   = 5'd2;
  localparam logic [4:0] TK_KW_BASE = 5'd3;
  localparam logic [4:0] TK_ASSIGN  = 5'd8;
  localparam logic [4:0] TK_PLUS    = 5'd9;
  localparam logic [4:0] TK_MINUS   = 5'd10;
  localparam logic [4:0] TK_STAR    = 5'd11;
  localparam logic [4:0] TK_SLASH   = 5'd12;
  localparam logic [4:0] TK_LT      = 5'd13;
  localparam logic [4:0] TK_GT      = 5'd14;
  localparam logic [4:0] TK_LE      = 5'd15;
  localparam logic [4:0] TK_GE      = 5'd16;
  localparam logic [4:0] TK_EQ      = 5'd17;
  localparam logic [4:0] TK_NEQ     = 5'd18;
  localparam logic [4:0] TK_LPAREN  = 5'd19;
  localparam logic [4:0] TK_RPAREN  = 5'd20;
  localparam logic [4:0] TK_LBRACE  = 5'd21;
  localparam logic [4:0] TK_RBRACE  = 5'd22;
  localparam logic [4:0] TK_COMMA   = 5'd23;
  localparam logic [4:0] TK_END     = 5'd24;

  // Characters with a role of their own
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int          NUM_KW     = 5;
  localparam int          RES_DEPTH  = 3;
  localparam logic [2:0]  LEN_MAX    = 3'd7;

  // Keyword text, padded with zeros to eight characters
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "o", "c", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd5};

  typedef enum logic [9:0] {
    MODE_IDLE      = 10'b00_0000_0001,
    MODE_COMMENT   = 10'b00_0000_0010,
    MODE_STRING    = 10'b00_0000_0100,
    MODE_NUMBER    = 10'b00_0000_1000,
    MODE_IDENT     = 10'b00_0001_0000,
    MODE_HOLD_LT   = 10'b00_0010_0000,
    MODE_HOLD_GT   = 10'b00_0100_0000,
    MODE_HOLD_EQ   = 10'b00_1000_0000,
    MODE_HOLD_BANG = 10'b01_0000_0000,
    MODE_HALTED    = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [1:0] rec_kind;
    logic [4:0] tok_kind;
    logic [7:0] val_byte;
  } rec_t;

  function automatic rec_t mk_rec(logic [1:0] rk, logic [4:0] tk, logic [7:0] vb);
    rec_t r;
    r.rec_kind = rk;
    r.tok_kind = tk;
    r.val_byte = vb;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // Drop every keyword candidate whose character at pos differs from c
  function automatic logic [NUM_KW-1:0] kw_match(logic [NUM_KW-1:0] cand,
                                                 logic [7:0] c, logic [2:0] pos);
    logic [NUM_KW-1:0] keep;
    for (int k = 0; k < NUM_KW; k++) begin
      keep[k] = cand[k] && (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
    end
    return keep;
  endfunction

  function automatic logic [4:0] ident_kind(logic [NUM_KW-1:0] cand, logic [2:0] len);
    logic [4:0] tk;
    tk = TK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == len)) begin
        tk = TK_KW_BASE + 5'(k);
      end
    end
    return tk;
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] tk;
    unique case (c)
      CH_PLUS:   tk = TK_PLUS;
      CH_MINUS:  tk = TK_MINUS;
      CH_STAR:   tk = TK_STAR;
      CH_SLASH:  tk = TK_SLASH;
      CH_LPAREN: tk = TK_LPAREN;
      CH_RPAREN: tk = TK_RPAREN;
      CH_COMMA:  tk = TK_COMMA;
      CH_LBRACE: tk = TK_LBRACE;
      CH_RBRACE: tk = TK_RBRACE;
      default:   tk = TK_NUM;
    endcase
    return tk;
  endfunction

endpackage

`default_nettype wire

[rtl/core/script_lexer_stream_core.sv]
// ----------------------------------------------------------------------------
// script_lexer_stream_core
// Streaming tokenizer: source bytes in, value, kind and error records out.
// ----------------------------------------------------------------------------
//
// Usage
//   The input channel carries one source byte per transfer in in_tdata; in_tlast
//   marks the last byte of a source. The output channel carries one record per
//   transfer: out_tuser holds the record kind (value, token complete, error),
//   out_tdata the token kind and the text byte, and out_tlast flags the final
//   record caused by one source byte. A byte may cause no record or up to three.
//   A byte taken waits in the input register until its records are loaded
//   into the result buffer. Throughput: one byte per cycle while each byte
//   yields at most one record and the receiver is ready; a byte yielding more
//   records holds the lexer until the single result buffer, which drains one
//   record per output transfer, is empty. Bytes yielding no record pass at one per cycle.
//   Reset clears the input register, the result buffer and the lexer state; the
//   block is then idle between tokens. After an error record every further byte
//   is taken and dropped until reset.
//   When the receiver stalls, the result buffer holds and one byte waits in the
//   input register; in_tready then falls.
//
`default_nettype none

module script_lexer_stream_core
  import slex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // end_of_source
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [4:0] token_kind, [12:5] value_byte, rest zero
  output      logic [1:0]  out_tuser,  // [1:0] record_kind
  output      logic        out_tlast   // last_of_run
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // Lexer state
  mode_t             mode_r, mode_nxt;
  logic [NUM_KW-1:0] cand_r, cand_nxt;
  logic [2:0]        len_r, len_nxt;

  // Result buffer: up to three records of one byte, drained in order
  rec_t       buf_r [RES_DEPTH];
  logic [1:0] cnt_r;
  logic [1:0] idx_r;

  // Records of the byte in the input register
  rec_t       recs [RES_DEPTH];
  logic [1:0] n_rec;

  logic       out_fire;
  logic       drain_last;
  logic       buf_free;
  logic       move;

  assign out_fire   = out_tvalid && out_tready;
  assign drain_last = out_fire && (idx_r == cnt_r - 2'd1);
  assign buf_free   = (cnt_r == 2'd0) || drain_last;
  assign move       = in_valid_r && buf_free;
  assign in_tready  = !in_valid_r || move;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = buf_r[idx_r].rec_kind;
  assign out_tdata  = {3'b000, buf_r[idx_r].val_byte, buf_r[idx_r].tok_kind};
  assign out_tlast  = (idx_r == cnt_r - 2'd1);

  // Lex one byte: close or continue the pending token, start a new one, then
  // flush at the end of the source.
  always_comb begin
    logic [7:0] c;
    logic       eos;
    logic       do_start;
    logic       sq_on;
    logic [7:0] sq_byte;

    c        = in_byte_r;
    eos      = in_eos_r;
    do_start = 1'b0;
    sq_on    = 1'b0;
    sq_byte  = '0;
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    len_nxt  = len_r;
    n_rec    = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      recs[i] = '0;
    end

    unique case (mode_r)
      MODE_HALTED: begin
        mode_nxt = MODE_HALTED;
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          recs[n_rec] = mk_rec(REC_KIND, TK_STR, 8'h00);
          n_rec       = n_rec + 2'd1;
          mode_nxt    = MODE_IDLE;
        end else begin
          recs[n_rec] = mk_rec(REC_VALUE, TK_STR, c);
          n_rec       = n_rec + 2'd1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c) || (c == CH_DOT)) begin
          recs[n_rec] = mk_rec(REC_VALUE, TK_NUM, c);
          n_rec       = n_rec + 2'd1;
        end else begin
          recs[n_rec] = mk_rec(REC_KIND, TK_NUM, 8'h00);
          n_rec       = n_rec + 2'd1;
          do_start    = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_word(c)) begin
          recs[n_rec] = mk_rec(REC_VALUE, TK_IDENT, c);
          n_rec       = n_rec + 2'd1;
          cand_nxt    = kw_match(cand_r, c, len_r);
          if (len_r < LEN_MAX) begin
            len_nxt = len_r + 3'd1;
          end
        end else begin
          recs[n_rec] = mk_rec(REC_KIND, ident_kind(cand_r, len_r), 8'h00);
          n_rec       = n_rec + 2'd1;
          cand_nxt    = '0;
          len_nxt     = '0;
          do_start    = 1'b1;
        end
      end
      MODE_HOLD_LT, MODE_HOLD_GT, MODE_HOLD_EQ, MODE_HOLD_BANG: begin
        if (c == CH_EQ) begin
          recs[n_rec] = mk_rec(REC_KIND,
                               (mode_r == MODE_HOLD_LT) ? TK_LE :
                               (mode_r == MODE_HOLD_GT) ? TK_GE :
                               (mode_r == MODE_HOLD_EQ) ? TK_EQ : TK_NEQ, 8'h00);
          n_rec       = n_rec + 2'd1;
          mode_nxt    = MODE_IDLE;
        end else if (mode_r == MODE_HOLD_BANG) begin
          recs[n_rec] = mk_rec(REC_ERROR, TK_NUM, CH_BANG);
          n_rec       = n_rec + 2'd1;
          mode_nxt    = MODE_HALTED;
        end else begin
          recs[n_rec] = mk_rec(REC_KIND,
                               (mode_r == MODE_HOLD_LT) ? TK_LT :
                               (mode_r == MODE_HOLD_GT) ? TK_GT : TK_ASSIGN, 8'h00);
          n_rec       = n_rec + 2'd1;
          do_start    = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Start of a new token
    if (do_start) begin
      mode_nxt = MODE_IDLE;
      if (is_space(c)) begin
        mode_nxt = MODE_IDLE;
      end else if (c == CH_HASH) begin
        mode_nxt = MODE_COMMENT;
      end else if (c == CH_QUOTE) begin
        mode_nxt = MODE_STRING;
      end else if (is_word(c)) begin
        // A one-byte token closed by the end of the source goes out in its
        // kind record alone when a record is already out for this byte
        if (eos && (n_rec != 2'd0)) begin
          sq_on   = 1'b1;
          sq_byte = c;
        end else begin
          recs[n_rec] = mk_rec(REC_VALUE, is_digit(c) ? TK_NUM : TK_IDENT, c);
          n_rec       = n_rec + 2'd1;
        end
        if (is_digit(c)) begin
          mode_nxt = MODE_NUMBER;
        end else begin
          mode_nxt = MODE_IDENT;
          cand_nxt = kw_match({NUM_KW{1'b1}}, c, 3'd0);
          len_nxt  = 3'd1;
        end
      end else if (c == CH_LT) begin
        mode_nxt = MODE_HOLD_LT;
      end else if (c == CH_GT) begin
        mode_nxt = MODE_HOLD_GT;
      end else if (c == CH_EQ) begin
        mode_nxt = MODE_HOLD_EQ;
      end else if (c == CH_BANG) begin
        mode_nxt = MODE_HOLD_BANG;
      end else if (is_single(c)) begin
        recs[n_rec] = mk_rec(REC_KIND, single_kind(c), 8'h00);
        n_rec       = n_rec + 2'd1;
      end else begin
        recs[n_rec] = mk_rec(REC_ERROR, TK_NUM, c);
        n_rec       = n_rec + 2'd1;
        mode_nxt    = MODE_HALTED;
      end
    end

    // End of source: flush the pending token, then END; a pending bang halts instead
    if (eos && (mode_nxt != MODE_HALTED)) begin
      if (mode_nxt == MODE_HOLD_BANG) begin
        recs[n_rec] = mk_rec(REC_ERROR, TK_NUM, CH_BANG);
        n_rec       = n_rec + 2'd1;
        mode_nxt    = MODE_HALTED;
      end else begin
        unique case (mode_nxt)
          MODE_STRING: begin
            recs[n_rec] = mk_rec(REC_KIND, TK_STR, 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          MODE_NUMBER: begin
            recs[n_rec] = mk_rec(REC_KIND, TK_NUM, sq_on ? sq_byte : 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          MODE_IDENT: begin
            recs[n_rec] = mk_rec(REC_KIND, ident_kind(cand_nxt, len_nxt),
                                 sq_on ? sq_byte : 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          MODE_HOLD_LT: begin
            recs[n_rec] = mk_rec(REC_KIND, TK_LT, 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          MODE_HOLD_GT: begin
            recs[n_rec] = mk_rec(REC_KIND, TK_GT, 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          MODE_HOLD_EQ: begin
            recs[n_rec] = mk_rec(REC_KIND, TK_ASSIGN, 8'h00);
            n_rec       = n_rec + 2'd1;
          end
          default: begin
            n_rec = n_rec;
          end
        endcase
        recs[n_rec] = mk_rec(REC_KIND, TK_END, 8'h00);
        n_rec       = n_rec + 2'd1;
        mode_nxt    = MODE_IDLE;
        cand_nxt    = '0;
        len_nxt     = '0;
      end
    end
  end

  // Input register: take a byte whenever the slot is empty or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  // Lexer state advances only when the byte's records enter the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cand_r <= '0;
      len_r  <= '0;
    end else if (move) begin
      mode_r <= mode_nxt;
      cand_r <= cand_nxt;
      len_r  <= len_nxt;
    end
  end

  // Result buffer: load on move, advance on each output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (move) begin
      cnt_r <= n_rec;
      idx_r <= '0;
    end else if (drain_last) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (out_fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        buf_r[i] <= recs[i];
      end
    end
  end

`ifndef SYNTHESIS
  // The buffer never claims more records than it has slots
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd3)
    else $error("result count out of range");

  // The read index stays inside the loaded records
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (idx_r < cnt_r))
    else $error("result index beyond record count");

  // Once halted the lexer stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HALTED) |=> (mode_r == MODE_HALTED))
    else $error("lexer left the halted mode");

  // A halted lexer drops bytes without producing records
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (move && (mode_r == MODE_HALTED)) |=> (cnt_r == 2'd0))
    else $error("record produced while halted");
`endif

endmodule

`default_nettype wire

[bench/tb_script_lexer_stream_core.sv]
// ----------------------------------------------------------------------------
// tb_script_lexer_stream_core
// Self-checking bench for the streaming script tokenizer.
// ----------------------------------------------------------------------------
// Source text is fed byte by byte over the input stream. Each byte is also run
// through a behavioural tokenizer in the bench, and the token records that it
// predicts are queued. Every record the core delivers is checked field by field
// against the oldest queued record. Four short hand-written sources open the run.
// Random programs follow: keywords and near misses, identifiers, numbers,
// strings, comments and operators, with several ways of ending a source. Both
// stream sides idle at several rates. The run closes by halting the core with a
// bad character and checking that it stays silent afterwards.
// ----------------------------------------------------------------------------

module tb_script_lexer_stream_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slex_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_LEN    = 24;
  localparam int PHASE_BYTES = 60;

  // One expected output record, with the flag that closes a byte's records
  typedef struct packed {
    logic [1:0] rec_kind;
    logic [4:0] tok_kind;
    logic [7:0] val_byte;
    logic       last;
  } token_rec_t;

  // Behavioural tokenizer plus the store of records still owed by the core
  class token_checker;
    mode_t       scan;
    logic [4:0]  kw_live;
    logic [2:0]  word_len;
    bit          squeezed;
    logic [7:0]  squeezed_byte;
    string       kw_text [NUM_KW];
    token_rec_t  step_recs[$];
    token_rec_t  expected_records[$];
    int unsigned mismatches;
    int unsigned records_seen;

    function new();
      kw_text      = '{"var", "proc", "while", "return", "print"};
      scan         = MODE_IDLE;
      kw_live      = '0;
      word_len     = '0;
      squeezed     = 1'b0;
      mismatches   = 0;
      records_seen = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function bit is_num(logic [7:0] c);
      return (c >= "0") && (c <= "9");
    endfunction

    function bit is_wordch(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             is_num(c) || (c == CH_UNDER);
    endfunction

    // TK_END stands for "not a one-character token"
    function logic [4:0] punct_kind(logic [7:0] c);
      case (c)
        CH_PLUS:   return TK_PLUS;
        CH_MINUS:  return TK_MINUS;
        CH_STAR:   return TK_STAR;
        CH_SLASH:  return TK_SLASH;
        CH_LPAREN: return TK_LPAREN;
        CH_RPAREN: return TK_RPAREN;
        CH_COMMA:  return TK_COMMA;
        CH_LBRACE: return TK_LBRACE;
        CH_RBRACE: return TK_RBRACE;
        default:   return TK_END;
      endcase
    endfunction

    function bit known_start(logic [7:0] c);
      return is_blank(c) || is_wordch(c) || (c == CH_HASH) || (c == CH_QUOTE) ||
             (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) || (c == CH_BANG) ||
             (punct_kind(c) != TK_END);
    endfunction

    // A byte never yields more than three records
    function void put(logic [1:0] rk, logic [4:0] tk, logic [7:0] vb);
      token_rec_t r;
      if (step_recs.size() >= RES_DEPTH) return;
      r.rec_kind = rk;
      r.tok_kind = tk;
      r.val_byte = vb;
      r.last     = 1'b0;
      step_recs.insert(step_recs.size(), r);
    endfunction

    function void halt(logic [7:0] c);
      put(REC_ERROR, '0, c);
      scan = MODE_HALTED;
    endfunction

    function void narrow_keywords(logic [7:0] c, int pos);
      for (int k = 0; k < NUM_KW; k++) begin
        if (!((pos < kw_text[k].len()) && (kw_text[k][pos] == c))) kw_live[k] = 1'b0;
      end
    endfunction

    function logic [4:0] word_kind();
      for (int k = 0; k < NUM_KW; k++) begin
        if (kw_live[k] && (kw_text[k].len() == word_len)) return TK_KW_BASE + 5'(k);
      end
      return TK_IDENT;
    endfunction

    function logic [4:0] held_kind(bit paired);
      case (scan)
        MODE_HOLD_LT: return paired ? TK_LE : TK_LT;
        MODE_HOLD_GT: return paired ? TK_GE : TK_GT;
        MODE_HOLD_EQ: return paired ? TK_EQ : TK_ASSIGN;
        default:      return TK_NEQ;
      endcase
    endfunction

    // A squeezed one-byte word carries its byte in the kind record
    function void close_word(logic [4:0] tk);
      put(REC_KIND, tk, squeezed ? squeezed_byte : 8'h00);
      squeezed = 1'b0;
    endfunction

    function void begin_token(logic [7:0] c, bit eos);
      scan = MODE_IDLE;
      if (is_blank(c)) return;
      if (c == CH_HASH) begin
        scan = MODE_COMMENT;
      end else if (c == CH_QUOTE) begin
        scan = MODE_STRING;
      end else if (is_wordch(c)) begin
        if (eos && (step_recs.size() > 0)) begin
          squeezed      = 1'b1;
          squeezed_byte = c;
        end else begin
          put(REC_VALUE, is_num(c) ? TK_NUM : TK_IDENT, c);
        end
        if (is_num(c)) begin
          scan = MODE_NUMBER;
        end else begin
          scan    = MODE_IDENT;
          kw_live = '1;
          narrow_keywords(c, 0);
          word_len = 3'd1;
        end
      end else if (c == CH_LT) begin
        scan = MODE_HOLD_LT;
      end else if (c == CH_GT) begin
        scan = MODE_HOLD_GT;
      end else if (c == CH_EQ) begin
        scan = MODE_HOLD_EQ;
      end else if (c == CH_BANG) begin
        scan = MODE_HOLD_BANG;
      end else if (punct_kind(c) != TK_END) begin
        put(REC_KIND, punct_kind(c), 8'h00);
      end else begin
        halt(c);
      end
    endfunction

    function void feed(logic [7:0] c, bit eos);
      case (scan)
        MODE_COMMENT: begin
          if (c == CH_NL) scan = MODE_IDLE;
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            put(REC_KIND, TK_STR, 8'h00);
            scan = MODE_IDLE;
          end else begin
            put(REC_VALUE, TK_STR, c);
          end
        end
        MODE_NUMBER: begin
          if (is_num(c) || (c == CH_DOT)) begin
            put(REC_VALUE, TK_NUM, c);
          end else begin
            close_word(TK_NUM);
            begin_token(c, eos);
          end
        end
        MODE_IDENT: begin
          if (is_wordch(c)) begin
            put(REC_VALUE, TK_IDENT, c);
            narrow_keywords(c, int'(word_len));
            if (word_len < LEN_MAX) word_len++;
          end else begin
            close_word(word_kind());
            kw_live  = '0;
            word_len = '0;
            begin_token(c, eos);
          end
        end
        MODE_HOLD_LT, MODE_HOLD_GT, MODE_HOLD_EQ, MODE_HOLD_BANG: begin
          if (c == CH_EQ) begin
            put(REC_KIND, held_kind(1'b1), 8'h00);
            scan = MODE_IDLE;
          end else if (scan == MODE_HOLD_BANG) begin
            halt(CH_BANG);
          end else begin
            put(REC_KIND, held_kind(1'b0), 8'h00);
            begin_token(c, eos);
          end
        end
        default: begin
          begin_token(c, eos);
        end
      endcase
    endfunction

    // End of source: close whatever is open, then END; a pending bang halts instead
    function void flush();
      case (scan)
        MODE_STRING: put(REC_KIND, TK_STR, 8'h00);
        MODE_NUMBER: close_word(TK_NUM);
        MODE_IDENT:  close_word(word_kind());
        MODE_HOLD_LT, MODE_HOLD_GT, MODE_HOLD_EQ: put(REC_KIND, held_kind(1'b0), 8'h00);
        MODE_HOLD_BANG: begin
          halt(CH_BANG);
          return;
        end
        default: ;
      endcase
      put(REC_KIND, TK_END, 8'h00);
      scan     = MODE_IDLE;
      kw_live  = '0;
      word_len = '0;
    endfunction

    function void note_byte(logic [7:0] c, bit eos);
      step_recs.delete();
      squeezed = 1'b0;
      if (scan == MODE_HALTED) return;
      feed(c, eos);
      if (eos && (scan != MODE_HALTED)) flush();
      if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
      foreach (step_recs[i]) expected_records.insert(expected_records.size(), step_recs[i]);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(logic [1:0] rk, logic [15:0] data, logic last);
      token_rec_t want;
      records_seen++;
      if (expected_records.size() == 0) begin
        $display("%0t: record with nothing expected: kind %0h tdata %h tlast %b",
                 $time, rk, data, last);
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      compare("record_kind", 8'(want.rec_kind), 8'(rk));
      compare("token_kind", 8'(want.tok_kind), 8'(data[4:0]));
      compare("value_byte", want.val_byte, data[12:5]);
      compare("last_of_run", 8'(want.last), 8'(last));
      compare("tdata padding", 8'h00, 8'(data[15:13]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  token_checker tok_chk = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_bytes     = 0;
  int unsigned sources        = 0;
  int unsigned cycles         = 0;
  logic [7:0]  src_q[$];
  string       op_spellings [16] = '{"=", "+", "-", "*", "/", "<", ">", "<=", ">=", "==",
                                     "!=", "(", ")", "{", "}", ","};
  string       squeeze_leads = "+-*/(),{}<>=";
  string       halt_how;

  script_lexer_stream_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: drop tready at the current stall rate, one decision per cycle
  always @(posedge clk) begin
    if ((recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct)) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every record transfer; values read here are those before the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tok_chk.check_record(out_tuser, out_tdata, out_tlast);
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d records outstanding", $time,
               tok_chk.expected_records.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte, hold it until the transfer, then predict its records.
  // tvalid is lowered only for an idle gap, so it never toggles within a step.
  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ((send_idle_pct != 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    tok_chk.note_byte(c, eos);
    sent_bytes++;
  endtask

  // Send src_q as one source: tlast on its final byte
  task automatic send_source();
    foreach (src_q[i]) send_byte(src_q[i], i == (src_q.size() - 1));
    sources++;
  endtask

  function automatic void add_byte(logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  // Build a well-formed program with random content in src_q. Unknown bytes
  // only land inside strings and comments, and '!' always comes as '!='.
  function automatic void build_program();
    int         pick;
    bit         after_word;
    string      kw;
    logic [7:0] b;
    src_q.delete();
    after_word = 1'b0;
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // keyword, a prefix of one, or one with a tail
        kw   = tok_chk.kw_text[$urandom_range(0, NUM_KW - 1)];
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          add_text(kw);
        end else if (pick < 8) begin
          add_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
        end else begin
          add_text(kw);
          repeat ($urandom_range(1, 4)) add_byte(rand_word_char());
        end
        after_word = 1'b1;
      end else if (pick < 40) begin
        do b = rand_word_char(); while (tok_chk.is_num(b));
        add_byte(b);
        repeat ($urandom_range(0, 9)) add_byte(rand_word_char());
        after_word = 1'b1;
      end else if (pick < 55) begin
        // a number glued to a word would turn its dots into bad characters
        if (after_word) add_byte(CH_SPACE);
        add_byte(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
          add_byte(($urandom_range(0, 3) == 0) ? CH_DOT : 8'("0" + $urandom_range(0, 9)));
        end
        after_word = 1'b0;
      end else if (pick < 65) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          add_byte(b);
        end
        add_byte(CH_QUOTE);
        after_word = 1'b0;
      end else if (pick < 70) begin
        add_byte(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
          add_byte(b);
        end
        add_byte(CH_NL);
        after_word = 1'b0;
      end else begin
        add_text(op_spellings[$urandom_range(0, 15)]);
        after_word = 1'b0;
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) begin
          b = 8'($urandom_range(8, 13));
          add_byte((b == 8'd8) ? CH_SPACE : b);
        end
        after_word = 1'b0;
      end
    end
    // How the source ends
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 3)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        add_byte(b);
      end
    end else if (pick < 22) begin
      add_byte(CH_HASH);
      repeat ($urandom_range(0, 3)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
        add_byte(b);
      end
    end else if (pick < 40) begin
      // one byte closes a token and starts a one-byte word on the last byte
      add_byte(squeeze_leads[$urandom_range(0, squeeze_leads.len() - 1)]);
      add_byte(rand_word_char());
    end
  endfunction

  initial begin
    logic [7:0]  junk;
    int unsigned goal;
    int          how;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: string holding the byte extremes, all four pairs, a comment
    // with a high byte, then a number closed by a squeezed last byte
    src_q = '{CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE, CH_LT, CH_EQ, CH_GT, CH_EQ, CH_EQ, CH_EQ,
              CH_BANG, CH_EQ, CH_HASH, 8'h80, CH_NL, "9", CH_DOT, "a"};
    send_source();
    // single-byte source, unterminated string, comment cut off by the end
    src_q = '{"x"};
    send_source();
    src_q = '{CH_QUOTE, "s"};
    send_source();
    src_q = '{CH_HASH, 8'hC3};
    send_source();

    // Random programs: no idling, sender gaps, receiver stalls, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 48;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 48;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase
      goal = sent_bytes + PHASE_BYTES;
      while (sent_bytes < goal) begin
        build_program();
        send_source();
      end
    end

    // Halt the lexer one of four ways, then feed bytes that must give nothing
    src_q.delete();
    add_text("a = ");
    how = $urandom_range(0, 3);
    case (how)
      0: begin
        halt_how = "a byte above 127";
        add_byte(8'($urandom_range(128, 255)));
      end
      1: begin
        halt_how = "an unknown ASCII character";
        do junk = 8'($urandom_range(0, 127)); while (tok_chk.known_start(junk));
        add_byte(junk);
      end
      2: begin
        halt_how = "a bang without equals";
        add_byte(CH_BANG);
        do junk = 8'($urandom_range(0, 255)); while (junk == CH_EQ);
        add_byte(junk);
      end
      default: begin
        halt_how = "a bang ending the source";
        add_byte(CH_BANG);
      end
    endcase
    send_source();
    repeat (TAIL_LEN) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_tvalid <= 1'b0;

    // Drain, then give stray records time to show up
    while (tok_chk.expected_records.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Lexed %0d bytes in %0d sources; %0d records compared, %0d mismatches",
             sent_bytes, sources, tok_chk.records_seen, tok_chk.mismatches);
    $display("Halted by %s, then %0d further bytes stayed silent or were flagged",
             halt_how, TAIL_LEN);
    if (tok_chk.mismatches == 0 && tok_chk.expected_records.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
